// File: rtl/core/mts_pkg.sv
`timescale 1ns / 1ps

package mts_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int ENTRY_W     = 2 * DATA_W;
    localparam int ECOUNT_W    = 11;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_QUERY = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_req                     req_type;
        logic signed [DATA_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] pop_value;
        logic                     has_top;
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] min_value;
        logic [ECOUNT_W-1:0]      entry_count;
    } t_out_item;

endpackage

// File: rtl/core/mts_ram.sv
`timescale 1ns / 1ps

module mts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/min_tracking_stack_top.sv
`timescale 1ns / 1ps
// channel | valid      | stall       | item
// --------+------------+-------------+-----------------------------
// request | i_in_valid | o_in_stall  | i_in_item  (t_in_item)
// result  | o_out_valid| i_out_stall | o_out_item (t_out_item)
//
// Push, clear, query, a pop that empties the stack and any error go straight to
// the result register. A pop that leaves entries behind first reads the new top
// from the entry RAM, whose read data is registered, and writes the result in S_READ.
// Reset clears the count, the sequencer and the result valid; RAM is not cleared.
// The request side stalls while a result waits under i_out_stall or a pop read
// is in flight.

module min_tracking_stack_top
    import mts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out_item, n_out_item;
    logic signed [DATA_W-1:0] r_top_val, n_top_val;
    logic signed [DATA_W-1:0] r_top_min, n_top_min;
    logic signed [DATA_W-1:0] r_pop_val, n_pop_val;

    logic                     accept;
    logic                     produce;
    t_status                  res_status;
    logic signed [DATA_W-1:0] res_pop;
    logic signed [DATA_W-1:0] push_min;

    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ENTRY_W-1:0]       wr_data;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic [ENTRY_W-1:0]       rd_data;

    mts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_count == '0) begin
            push_min = i_in_item.push_value;
        end else if (i_in_item.push_value < r_top_min) begin
            push_min = i_in_item.push_value;
        end else begin
            push_min = r_top_min;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_top_val  = r_top_val;
        n_top_min  = r_top_min;
        n_pop_val  = r_pop_val;
        produce    = 1'b0;
        res_status = ST_OK;
        res_pop    = '0;
        wr_en      = 1'b0;
        wr_addr    = r_count[ADDR_W-1:0];
        wr_data    = {i_in_item.push_value, push_min};
        rd_en      = 1'b0;
        rd_addr    = ADDR_W'(r_count - CNT_W'(2));

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_in_item.req_type)
                        REQ_PUSH: begin
                            produce = 1'b1;
                            if (r_count == CNT_W'(STACK_DEPTH)) begin
                                res_status = ST_FULL;
                            end else begin
                                wr_en     = 1'b1;
                                n_top_val = i_in_item.push_value;
                                n_top_min = push_min;
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        REQ_POP: begin
                            if (r_count == '0) begin
                                produce    = 1'b1;
                                res_status = ST_EMPTY;
                            end else begin
                                n_count   = r_count - CNT_W'(1);
                                n_pop_val = r_top_val;
                                res_pop   = r_top_val;
                                if (r_count == CNT_W'(1)) begin
                                    produce = 1'b1;
                                end else begin
                                    // fetch the entry that becomes the new top
                                    rd_en   = 1'b1;
                                    n_state = S_READ;
                                end
                            end
                        end
                        REQ_CLEAR: begin
                            produce = 1'b1;
                            n_count = '0;
                        end
                        REQ_QUERY: begin
                            produce = 1'b1;
                            if (r_count == '0) begin
                                res_status = ST_EMPTY;
                            end
                        end
                        default: begin
                            produce = 1'b0;
                        end
                    endcase
                end
            end
            S_READ: begin
                produce   = 1'b1;
                res_pop   = r_pop_val;
                n_top_val = rd_data[ENTRY_W-1:DATA_W];
                n_top_min = rd_data[DATA_W-1:0];
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_item = r_out_item;
        if (produce) begin
            n_out_item.status      = res_status;
            n_out_item.pop_value   = res_pop;
            n_out_item.has_top     = (n_count != '0);
            n_out_item.top_value   = (n_count != '0) ? n_top_val : '0;
            n_out_item.min_value   = (n_count != '0) ? n_top_min : '0;
            n_out_item.entry_count = ECOUNT_W'(n_count);
        end
        // hold a stalled result, drop a taken one
        n_out_valid = produce || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
        r_top_val  <= n_top_val;
        r_top_min  <= n_top_min;
        r_pop_val  <= n_pop_val;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mts_pkg::*;

    localparam logic signed [DATA_W-1:0] VMIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VMAX = 32'sh7FFF_FFFF;
    localparam int RANDOM_PER_PHASE = 316;
    localparam int LONG_HOLD        = 60;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int DRAIN_CYCLES     = 8;

    typedef enum int {
        MODE_GROW,
        MODE_SHRINK,
        MODE_MIXED,
        MODE_FILL
    } t_burst_mode;

    typedef struct packed {
        t_req                     req;
        logic signed [DATA_W-1:0] value;
        logic [15:0]              reps;
        logic                     rand_val;
        logic                     typed;
        t_out_item                res;
    } t_stim_row;

    localparam t_out_item EMPTY_ERR = '{ST_EMPTY, 32'sd0, 1'b0, 32'sd0, 32'sd0, 11'd0};
    localparam t_out_item CLEARED   = '{ST_OK, 32'sd0, 1'b0, 32'sd0, 32'sd0, 11'd0};
    localparam t_out_item NO_RES    = '0;

    localparam int N_ROWS = 25;
    // typed rows carry their own result; the rest are checked against apply_request
    localparam t_stim_row DIRECTED [N_ROWS] = '{
        '{REQ_QUERY, 32'sd0, 16'd1, 1'b1, 1'b1, EMPTY_ERR},
        '{REQ_POP,   32'sd0, 16'd1, 1'b1, 1'b1, EMPTY_ERR},
        '{REQ_CLEAR, 32'sd0, 16'd1, 1'b1, 1'b1, CLEARED},
        '{REQ_PUSH,  VMIN,   16'd1, 1'b0, 1'b1, '{ST_OK, 32'sd0, 1'b1, VMIN, VMIN, 11'd1}},
        '{REQ_PUSH,  VMAX,   16'd1, 1'b0, 1'b1, '{ST_OK, 32'sd0, 1'b1, VMAX, VMIN, 11'd2}},
        '{REQ_QUERY, 32'sd0, 16'd1, 1'b1, 1'b1, '{ST_OK, 32'sd0, 1'b1, VMAX, VMIN, 11'd2}},
        '{REQ_POP,   32'sd0, 16'd1, 1'b1, 1'b1, '{ST_OK, VMAX, 1'b1, VMIN, VMIN, 11'd1}},
        '{REQ_POP,   32'sd0, 16'd1, 1'b1, 1'b1, '{ST_OK, VMIN, 1'b0, 32'sd0, 32'sd0, 11'd0}},
        '{REQ_PUSH,  32'sd0, 16'd1, 1'b0, 1'b1, '{ST_OK, 32'sd0, 1'b1, 32'sd0, 32'sd0, 11'd1}},
        '{REQ_PUSH,  -32'sd1, 16'd1, 1'b0, 1'b1,
            '{ST_OK, 32'sd0, 1'b1, -32'sd1, -32'sd1, 11'd2}},
        '{REQ_PUSH,  32'sd7, 16'd1, 1'b0, 1'b0, NO_RES},
        '{REQ_PUSH,  -32'sd1, 16'd1, 1'b0, 1'b0, NO_RES},
        '{REQ_POP,   32'sd0, 16'd1, 1'b1, 1'b0, NO_RES},
        '{REQ_POP,   32'sd0, 16'd1, 1'b1, 1'b0, NO_RES},
        '{REQ_CLEAR, 32'sd0, 16'd1, 1'b1, 1'b1, CLEARED},
        '{REQ_PUSH,  32'sh5555_5555, 16'd1, 1'b0, 1'b0, NO_RES},
        '{REQ_PUSH,  32'shAAAA_AAAA, 16'd1, 1'b0, 1'b0, NO_RES},
        '{REQ_PUSH,  32'sd0, 16'(STACK_DEPTH - 2), 1'b1, 1'b0, NO_RES},
        '{REQ_PUSH,  32'sd0, 16'd2, 1'b1, 1'b0, NO_RES},
        '{REQ_QUERY, 32'sd0, 16'd1, 1'b1, 1'b0, NO_RES},
        '{REQ_POP,   32'sd0, 16'd3, 1'b1, 1'b0, NO_RES},
        '{REQ_PUSH,  32'sd0, 16'd4, 1'b1, 1'b0, NO_RES},
        '{REQ_CLEAR, 32'sd0, 16'd1, 1'b1, 1'b1, CLEARED},
        '{REQ_POP,   32'sd0, 16'd1, 1'b1, 1'b1, EMPTY_ERR},
        '{REQ_QUERY, 32'sd0, 16'd1, 1'b1, 1'b1, EMPTY_ERR}
    };

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    min_tracking_stack_top uut (.*);

    // shadow copy of the stack
    logic signed [DATA_W-1:0] shadow_val [STACK_DEPTH];
    logic signed [DATA_W-1:0] shadow_min [STACK_DEPTH];
    int shadow_fill;

    t_out_item results_due [$];
    int fail_count;
    int requests_sent;
    int req_seen [4];
    int full_refusals;
    int empty_refusals;
    int peak_fill;
    int in_idle_pct;
    int out_idle_pct;
    int run_phase;

    wire in_fire  = i_in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !i_out_stall;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic t_out_item apply_request(t_in_item item);
        t_out_item res;
        logic signed [DATA_W-1:0] run_min;
        res = '0;
        res.status = ST_OK;
        req_seen[item.req_type]++;
        case (item.req_type)
            REQ_PUSH: begin
                if (shadow_fill >= STACK_DEPTH) begin
                    res.status = ST_FULL;
                    full_refusals++;
                end else begin
                    run_min = item.push_value;
                    if (shadow_fill > 0 && shadow_min[shadow_fill-1] < run_min)
                        run_min = shadow_min[shadow_fill-1];
                    shadow_val[shadow_fill] = item.push_value;
                    shadow_min[shadow_fill] = run_min;
                    shadow_fill++;
                end
            end
            REQ_POP: begin
                if (shadow_fill == 0) begin
                    res.status = ST_EMPTY;
                    empty_refusals++;
                end else begin
                    shadow_fill--;
                    res.pop_value = shadow_val[shadow_fill];
                end
            end
            REQ_CLEAR: begin
                shadow_fill = 0;
            end
            default: begin
                if (shadow_fill == 0) begin
                    res.status = ST_EMPTY;
                    empty_refusals++;
                end
            end
        endcase
        if (shadow_fill > 0) begin
            res.has_top   = 1'b1;
            res.top_value = shadow_val[shadow_fill-1];
            res.min_value = shadow_min[shadow_fill-1];
        end
        res.entry_count = ECOUNT_W'(shadow_fill);
        if (shadow_fill > peak_fill)
            peak_fill = shadow_fill;
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return VMIN;
            1: return VMAX;
            2: return 32'sd0;
            3: return -32'sd1;
            4, 5: return $signed($urandom_range(0, 20)) - 32'sd10;
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic t_req pick_req(t_burst_mode mode);
        int roll;
        int push_cut;
        int pop_cut;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_GROW: begin
                push_cut = 70;
                pop_cut  = 85;
            end
            MODE_SHRINK: begin
                push_cut = 20;
                pop_cut  = 85;
            end
            MODE_FILL: begin
                push_cut = 100;
                pop_cut  = 100;
            end
            default: begin
                push_cut = 40;
                pop_cut  = 80;
            end
        endcase
        if (roll < push_cut)
            return REQ_PUSH;
        if (roll < pop_cut)
            return REQ_POP;
        if (roll < 97)
            return REQ_QUERY;
        return REQ_CLEAR;
    endfunction

    task automatic send_request(input t_in_item item, input logic typed,
                                input t_out_item typed_res);
        t_out_item predicted;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item  = item;
        do @(posedge i_clk); while (o_in_stall);
        predicted = apply_request(item);
        results_due.push_back(typed ? typed_res : predicted);
        requests_sent++;
    endtask

    task automatic check_result(input t_out_item want, input t_out_item got);
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            fail_count++;
        end
        if (got.pop_value !== want.pop_value) begin
            $display("%0t: pop_value expected %0d actual %0d",
                     $time, want.pop_value, got.pop_value);
            fail_count++;
        end
        if (got.has_top !== want.has_top) begin
            $display("%0t: has_top expected %0d actual %0d", $time, want.has_top, got.has_top);
            fail_count++;
        end
        if (got.top_value !== want.top_value) begin
            $display("%0t: top_value expected %0d actual %0d",
                     $time, want.top_value, got.top_value);
            fail_count++;
        end
        if (got.min_value !== want.min_value) begin
            $display("%0t: min_value expected %0d actual %0d",
                     $time, want.min_value, got.min_value);
            fail_count++;
        end
        if (got.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want.entry_count, got.entry_count);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_fire) begin
            if (results_due.size() == 0) begin
                $display("%0t: result expected none actual %p", $time, o_out_item);
                fail_count++;
            end else begin
                check_result(results_due.pop_front(), o_out_item);
            end
        end
    end

    // result side: random stalls, plus one long hold at the start of each random phase
    initial begin
        int hold_left;
        int seen_phase;
        hold_left   = 0;
        seen_phase  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run_phase != seen_phase) begin
                seen_phase = run_phase;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                i_out_stall = ($urandom_range(0, 99) < out_idle_pct);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || in_fire || out_fire)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin
        t_in_item    item;
        t_burst_mode mode;
        int          burst_len;
        int          phase_sent;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_item      = '0;
        shadow_fill    = 0;
        fail_count     = 0;
        requests_sent  = 0;
        req_seen       = '{0, 0, 0, 0};
        full_refusals  = 0;
        empty_refusals = 0;
        peak_fill      = 0;
        in_idle_pct    = 15;
        out_idle_pct   = 59;
        run_phase      = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED[r]) begin
            for (int k = 0; k < int'(DIRECTED[r].reps); k++) begin
                item.req_type   = DIRECTED[r].req;
                item.push_value = DIRECTED[r].rand_val ? pick_value() : DIRECTED[r].value;
                send_request(item, DIRECTED[r].typed, DIRECTED[r].res);
            end
        end

        for (int ph = 1; ph <= 3; ph++) begin
            case (ph)
                1: begin
                    in_idle_pct  = 15;
                    out_idle_pct = 59;
                end
                2: begin
                    in_idle_pct  = 59;
                    out_idle_pct = 15;
                end
                default: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            run_phase  = ph;
            phase_sent = 0;
            while (phase_sent < RANDOM_PER_PHASE) begin
                if ($urandom_range(0, 39) == 0) begin
                    mode      = MODE_FILL;
                    burst_len = STACK_DEPTH - shadow_fill + 2;
                end else begin
                    mode      = t_burst_mode'($urandom_range(0, 2));
                    burst_len = $urandom_range(8, 64);
                end
                for (int k = 0; k < burst_len && phase_sent < RANDOM_PER_PHASE; k++) begin
                    item.req_type   = pick_req(mode);
                    item.push_value = pick_value();
                    send_request(item, 1'b0, NO_RES);
                    phase_sent++;
                end
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (results_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d requests: %0d push, %0d pop, %0d clear, %0d query",
                 requests_sent, req_seen[REQ_PUSH], req_seen[REQ_POP],
                 req_seen[REQ_CLEAR], req_seen[REQ_QUERY]);
        $display("peak depth %0d of %0d, %0d full refusals, %0d empty refusals, %0d errors",
                 peak_fill, STACK_DEPTH, full_refusals, empty_refusals, fail_count);
        if (fail_count == 0 && results_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: min_tracking_stack_top.f
rtl/core/mts_pkg.sv
rtl/core/mts_ram.sv
rtl/core/min_tracking_stack_top.sv
verif/testbench.sv
